### rtl/lds_pkg.sv
// shared constants and types for the linear diophantine solver
package lds_pkg;
  localparam int COEF_WIDTH = 32;
  localparam int DW = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVC,
    ST_DIVA,
    ST_DIVB,
    ST_EUC,
    ST_BACK,
    ST_LOADQ,
    ST_MULX,
    ST_MULY,
    ST_DONE
  } state_t;
endpackage

### rtl/linear_diophantine_solver.sv
// linear diophantine solver top level, iterative extended euclid
//
// usage: one equation a*x + b*y = c is handed over per input transfer
//   in_tdata  = {rhs_c, coef_b, coef_a}, highest field first
//   out_tdata = {y_base, y_step, x_base, x_step}, highest field first
//   out_tuser = solvable
// the block takes one item at a time; in_tready is high only while idle
// and the output register is empty, so the next item can go in the cycle
// after the result transfer.
// one shared unit does every gcd step, the divisions by g and every euclid
// quotient as a restoring divide, and
// the back substitution products as a shift-add multiply.
// a rejected item or a failed divisibility test ends early; a rejected
// item shows its result in the cycle after the input transfer.
// reset (rst_n low, synchronous) returns to idle and empties the output.
// a stalled receiver holds the result in the output register; no new
// item is taken until it is transferred.
module linear_diophantine_solver (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // coef_a, coef_b, rhs_c
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // x_step, x_base, y_step, y_base
  output logic [0:0]   out_tuser   // solvable
);
  import lds_pkg::*;

  localparam logic signed [DW-1:0] MINV = -(64'sd1 <<< (COEF_WIDTH-1));

  state_t st_r, st_nxt;

  // shared unit: divider (n / d, truncating) or multiplier on magnitudes,
  // signs handled outside
  logic [DW-1:0] dn_r, dd_r, dq_r, drem_r, prod_r;
  logic [5:0]    cnt_r;
  logic          busy_r, mul_r, neg_r, nneg_r;

  logic signed [DW-1:0] a_r, b_r, c_r, g_r, ap_r, bp_r, cp_r, ra_r, rb_r;
  logic signed [DW-1:0] x_r, y_r, res_x_r, res_y_r, q_rd_r;
  logic signed [DW-1:0] quot_mem [0:63];
  logic [6:0]    n_r, i_r;
  logic          ovalid_r, osolv_r;

  logic signed [DW-1:0] sa, sb, sc;
  logic [DW:0]   trial;
  logic [DW-1:0] rem_sh;
  logic signed [DW-1:0] q_s, r_s, p_s;
  logic signed [DW-1:0] op_n, op_d;
  logic          go_div, go_mul, fin, reject, q_we, in_xfer;

  function automatic logic [DW-1:0] absv(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  assign sa = DW'($signed(in_tdata[COEF_WIDTH-1:0]));
  assign sb = DW'($signed(in_tdata[32+COEF_WIDTH-1:32]));
  assign sc = DW'($signed(in_tdata[64+COEF_WIDTH-1:64]));

  // coefficients that have no defined answer
  assign reject = (sa == 0) || (sa == MINV) || (sb == 0) || (sb == MINV) || (sc == MINV);

  // one restoring step
  assign rem_sh = {drem_r[DW-2:0], dn_r[DW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dd_r};
  assign q_s = neg_r ? -$signed(dq_r) : $signed(dq_r);
  assign r_s = nneg_r ? -$signed(drem_r) : $signed(drem_r);
  assign p_s = neg_r ? -$signed(prod_r) : $signed(prod_r);

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = (st_r == ST_IDLE) && !ovalid_r;
  assign q_we      = (st_r == ST_EUC) && !busy_r;

  // sequencer: next state and unit start requests
  always_comb begin
    st_nxt = st_r;
    go_div = 1'b0;
    go_mul = 1'b0;
    fin    = 1'b0;
    op_n   = '0;
    op_d   = '0;
    unique case (st_r)
      ST_IDLE: if (in_xfer) begin
        if (reject) begin
          fin = 1'b1;
        end else begin
          st_nxt = ST_GCD;
          go_div = 1'b1;
          op_n   = absv(sb);
          op_d   = absv(sa);
        end
      end
      ST_GCD: if (!busy_r) begin
        go_div = 1'b1;
        if (r_s == 0) begin
          // gcd found, test whether it divides c
          st_nxt = ST_DIVC;
          op_n   = c_r;
          op_d   = ra_r;
        end else begin
          op_n = ra_r;
          op_d = r_s;
        end
      end
      ST_DIVC: if (!busy_r) begin
        if (r_s != 0) begin
          fin    = 1'b1;
          st_nxt = ST_IDLE;
        end else begin
          st_nxt = ST_DIVA;
          go_div = 1'b1;
          op_n   = a_r;
          op_d   = g_r;
        end
      end
      ST_DIVA: if (!busy_r) begin
        st_nxt = ST_DIVB;
        go_div = 1'b1;
        op_n   = b_r;
        op_d   = g_r;
      end
      ST_DIVB: if (!busy_r) begin
        st_nxt = ST_EUC;
        go_div = 1'b1;
        op_n   = q_s;
        op_d   = ap_r;
      end
      ST_EUC: if (!busy_r) begin
        if (r_s == 0 || n_r == 7'd63) begin
          st_nxt = ST_BACK;
        end else begin
          go_div = 1'b1;
          op_n   = ra_r;
          op_d   = r_s;
        end
      end
      ST_BACK: begin
        if (i_r == 7'd0) begin
          // sign fix of the euclid gcd folded into the x product
          st_nxt = ST_MULX;
          go_mul = 1'b1;
          op_n   = rb_r[DW-1] ? -x_r : x_r;
          op_d   = cp_r;
        end else begin
          st_nxt = ST_LOADQ;
        end
      end
      ST_LOADQ: begin
        st_nxt = ST_MULY;
        go_mul = 1'b1;
        op_n   = q_rd_r;
        op_d   = x_r;
      end
      ST_MULY: if (!busy_r) st_nxt = ST_BACK;
      ST_MULX: if (!busy_r) begin
        st_nxt = ST_DONE;
        go_mul = 1'b1;
        op_n   = y_r;
        op_d   = cp_r;
      end
      ST_DONE: if (!busy_r) begin
        fin    = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // output valid and unit busy/count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      busy_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (fin) ovalid_r <= 1'b1;
      else if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (go_div || go_mul) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) busy_r <= 1'b0;
      end
    end
  end

  // shared unit datapath
  always_ff @(posedge clk) begin
    if (go_div || go_mul) begin
      dn_r   <= absv(op_n);
      dd_r   <= absv(op_d);
      dq_r   <= '0;
      drem_r <= '0;
      prod_r <= '0;
      mul_r  <= go_mul;
      neg_r  <= op_n[DW-1] ^ op_d[DW-1];
      nneg_r <= op_n[DW-1];
    end else if (busy_r) begin
      if (mul_r) begin
        if (dn_r[0]) prod_r <= prod_r + dd_r;
        dn_r <= dn_r >> 1;
        dd_r <= dd_r << 1;
      end else begin
        dn_r <= {dn_r[DW-2:0], 1'b0};
        if (!trial[DW]) begin
          drem_r <= trial[DW-1:0];
          dq_r   <= {dq_r[DW-2:0], 1'b1};
        end else begin
          drem_r <= rem_sh;
          dq_r   <= {dq_r[DW-2:0], 1'b0};
        end
      end
    end
  end

  // euclid quotient store, registered read at the back substitution index
  always_ff @(posedge clk) begin
    if (q_we) quot_mem[n_r[5:0]] <= q_s;
    q_rd_r <= quot_mem[i_r[5:0] - 6'd1];
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: if (in_xfer) begin
        a_r  <= sa;
        b_r  <= sb;
        c_r  <= sc;
        ra_r <= absv(sa);
        rb_r <= absv(sb);
        if (reject) begin
          osolv_r <= 1'b0;
          res_x_r <= '0;
          res_y_r <= '0;
          ap_r    <= '0;
          bp_r    <= '0;
        end
      end
      ST_GCD: if (!busy_r) begin
        if (r_s == 0) begin
          g_r <= ra_r;
        end else begin
          rb_r <= ra_r;
          ra_r <= r_s;
        end
      end
      ST_DIVC: if (!busy_r) begin
        if (r_s != 0) begin
          osolv_r <= 1'b0;
          res_x_r <= '0;
          res_y_r <= '0;
          ap_r    <= '0;
          bp_r    <= '0;
        end else begin
          cp_r <= q_s;
        end
      end
      ST_DIVA: if (!busy_r) ap_r <= q_s;
      ST_DIVB: if (!busy_r) begin
        bp_r <= q_s;
        ra_r <= ap_r;
        rb_r <= q_s;
        n_r  <= '0;
      end
      ST_EUC: if (!busy_r) begin
        n_r  <= n_r + 7'd1;
        rb_r <= ra_r;
        ra_r <= r_s;
        if (r_s == 0 || n_r == 7'd63) begin
          x_r <= '0;
          y_r <= 64'sd1;
          i_r <= n_r + 7'd1;
        end
      end
      ST_BACK: begin
        if (i_r == 7'd0) begin
          if (rb_r[DW-1]) begin
            x_r <= -x_r;
            y_r <= -y_r;
          end
        end else begin
          i_r <= i_r - 7'd1;
        end
      end
      ST_MULY: if (!busy_r) begin
        // back-substitution step: nx = y - q*x
        x_r <= y_r - p_s;
        y_r <= x_r;
      end
      ST_MULX: if (!busy_r) res_x_r <= p_s;
      ST_DONE: if (!busy_r) begin
        res_y_r <= p_s;
        osolv_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = osolv_r;
  assign out_tdata  = {res_y_r, 32'(-ap_r), res_x_r, bp_r[31:0]};
endmodule

### rtl/lds_checker.sv
// port-level checker for the linear diophantine solver
module lds_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [191:0] out_tdata,
  input logic [0:0] out_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("took item while busy");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("ready while result pending");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[95:64] == 32'd0)
    else $error("unsolvable result not zero");
endmodule

bind linear_diophantine_solver lds_checker u_chk (.*);

### verif/linear_diophantine_solver_tb.sv
// testbench for the linear diophantine solver: directed and random equations checked
// against a behavioral extended-euclid predictor
module linear_diophantine_solver_tb;
  import lds_pkg::*;

  typedef struct {
    logic        solvable;
    logic [31:0] x_step;
    logic [63:0] x_base;
    logic [31:0] y_step;
    logic [63:0] y_base;
  } solution_t;

  // extended euclid predictor, one solution per equation
  function automatic solution_t solve_equation(logic [31:0] ra, logic [31:0] rb,
                                               logic [31:0] rc);
    solution_t s;
    longint a, b, c, g, p, q, r, ap, bp, cp, ua, ub, x, y, nx;
    longint minv;
    longint quots[64];
    int n;
    s = '{1'b0, '0, '0, '0, '0};
    minv = -(64'sd1 <<< (COEF_WIDTH - 1));
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    c = longint'($signed(rc));
    if (a == 0 || a == minv || b == 0 || b == minv || c == minv) return s;
    p = a < 0 ? -a : a;
    q = b < 0 ? -b : b;
    while (p != 0) begin
      r = q % p;
      q = p;
      p = r;
    end
    g = q;
    if (c % g != 0) return s;
    ap = a / g;
    bp = b / g;
    cp = c / g;
    ua = ap;
    ub = bp;
    n = 0;
    while (ua != 0 && n < 64) begin
      r = ub % ua;
      quots[n] = ub / ua;
      ub = ua;
      ua = r;
      n++;
    end
    x = 0;
    y = 1;
    for (int i = n - 1; i >= 0; i--) begin
      nx = y - quots[i] * x;
      y = x;
      x = nx;
    end
    if (ub < 0) begin
      x = -x;
      y = -y;
    end
    s.solvable = 1'b1;
    s.x_step = bp[31:0];
    s.x_base = x * cp;
    s.y_step = 32'(-ap);
    s.y_base = y * cp;
    return s;
  endfunction

  class solution_board;
    solution_t pending[$];
    int errors, checked, solvable_seen;

    function void note_equation(logic [95:0] d);
      pending.push_back(solve_equation(d[31:0], d[63:32], d[95:64]));
    endfunction

    function void check_solution(logic [191:0] d, logic sv);
      solution_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%b", $time, d, sv);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.solvable) solvable_seen++;
      if (sv !== e.solvable) begin
        $display("%0t: solvable exp %b got %b", $time, e.solvable, sv);
        errors++;
      end
      if (d[31:0] !== e.x_step) begin
        $display("%0t: x_step exp %h got %h", $time, e.x_step, d[31:0]);
        errors++;
      end
      if (d[95:32] !== e.x_base) begin
        $display("%0t: x_base exp %h got %h", $time, e.x_base, d[95:32]);
        errors++;
      end
      if (d[127:96] !== e.y_step) begin
        $display("%0t: y_step exp %h got %h", $time, e.y_step, d[127:96]);
        errors++;
      end
      if (d[191:128] !== e.y_base) begin
        $display("%0t: y_base exp %h got %h", $time, e.y_base, d[191:128]);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [95:0] in_tdata;
  logic [191:0] out_tdata;
  logic [0:0] out_tuser;

  solution_board board = new();
  int sent;
  bit hold_req;  // asks the receiver for one long hold-off

  linear_diophantine_solver u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, occasionally a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // random coefficient biased toward small magnitudes so euclid stays short
  function automatic logic [31:0] rand_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'($signed($urandom_range(0, 40)) - 20);
    if (r < 65) return 32'($signed($urandom_range(0, 2000)) - 1000);
    if (r < 75) return $urandom & 32'h0000_ffff;
    if (r < 80) return 32'h8000_0000;
    if (r < 85) return 32'h0;
    return $urandom;
  endfunction

  // a*x+b*y=c, in most cases with all three scaled by a shared factor
  function automatic logic [95:0] rand_equation();
    logic [31:0] a, b, c;
    int k;
    a = rand_coef();
    b = rand_coef();
    c = rand_coef();
    if ($urandom_range(0, 99) < 60) begin
      k = $urandom_range(1, 12);
      a = 32'($signed(a) % 100000 * k);
      b = 32'($signed(b) % 100000 * k);
      c = 32'($signed(c) % 100000 * k);
    end
    return {c, b, a};
  endfunction

  // valid stays high into the next item when there is no gap
  task automatic send_equation(logic [95:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tdata <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_equation(d);
    sent++;
    @(negedge clk);
  endtask

  // receiver: random stalls plus one long hold while the sender keeps offering
  initial begin
    int g;
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (20000) @(negedge clk);
      end
      g = gap_len();
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (g) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_solution(out_tdata, out_tuser[0]);
  end

  initial begin
    logic [31:0] edge_vals[6];
    in_tvalid = 1'b0;
    in_tdata = '0;
    rst_n = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    edge_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h0, 32'h1, 32'hffff_ffff};
    // extremes of the fields, rejected coefficients, no solution, zero rhs
    send_equation({32'd7, 32'd5, 32'd3});
    send_equation({32'd0, 32'd4, 32'd6});
    send_equation({32'd3, 32'd4, 32'd6});
    send_equation({32'd7, 32'd0, 32'd3});
    send_equation({32'd7, 32'd3, 32'd0});
    send_equation({32'h8000_0000, 32'd3, 32'd2});
    send_equation({32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff});
    send_equation({32'h8000_0001, 32'h8000_0001, 32'h7fff_ffff});
    send_equation({32'hffff_fff6, 32'hffff_fffc, 32'hffff_fffa});
    for (int i = 0; i < 6; i++)
      send_equation({edge_vals[(i + 2) % 6], edge_vals[(i + 1) % 6], edge_vals[i]});
    send_equation({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    // long receiver hold-off: sender keeps offering until the block stalls
    hold_req = 1'b1;
    for (int i = 0; i < 1150; i++) send_equation(rand_equation());
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("ran %0d equations, %0d results checked, %0d of them solvable",
             sent, board.checked, board.solvable_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[linear_diophantine_solver] OK");
    end else begin
      $display("[linear_diophantine_solver] ERROR");
    end
    $finish;
  end

  // timeout covering the worst case per item plus stalls, taken several times over
  initial begin
    #500000000;
    $display("timeout after %0d equations sent", sent);
    $display("[linear_diophantine_solver] ERROR");
    $finish;
  end
endmodule
